@@ hdl/tpr_pkg.sv @@
`timescale 1ns / 1ps
package tpr_pkg;

  localparam int SAMPLE_WIDTH    = 16;
  localparam int ANGLE_FRAC_BITS = 8;
  localparam int CORDIC_STEPS    = 16;
  localparam int GUARD_BITS      = 31 - SAMPLE_WIDTH;
  localparam int TABLE_LEN       = 24;
  localparam int TABLE_FRAC      = 24;
  localparam int ANGLE_W         = 16;
  localparam int MAG_W           = SAMPLE_WIDTH + 1;
  localparam int SUM_W           = 2 * SAMPLE_WIDTH;
  localparam int ROOT_W          = SAMPLE_WIDTH + GUARD_BITS;
  localparam int REM_W           = 2 * ROOT_W + 2;
  localparam int CW              = ROOT_W + 5;
  localparam int ZW              = 34;
  localparam int FULL_ANGLE      = 90 * (2 ** ANGLE_FRAC_BITS);

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] accel_x;
    logic signed [SAMPLE_WIDTH-1:0] accel_y;
    logic signed [SAMPLE_WIDTH-1:0] accel_z;
  } tpr_in_t;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] pitch_angle;
    logic signed [ANGLE_W-1:0] roll_angle;
    logic                      pitch_undefined;
    logic                      roll_undefined;
  } tpr_out_t;

  // per-angle sideband that rides along the pipeline
  typedef struct packed {
    logic neg;
    logic num_zero;
    logic den_zero;
  } tpr_side_t;

  // atan(2^-i) in degrees scaled by 2^24
  function automatic logic signed [ZW-1:0] atan_deg(input int i);
    logic signed [ZW-1:0] v;
    unique case (i)
      0:  v = ZW'(754974720);
      1:  v = ZW'(445687602);
      2:  v = ZW'(235489088);
      3:  v = ZW'(119537938);
      4:  v = ZW'(60000934);
      5:  v = ZW'(30029717);
      6:  v = ZW'(15018523);
      7:  v = ZW'(7509720);
      8:  v = ZW'(3754917);
      9:  v = ZW'(1877466);
      10: v = ZW'(938734);
      11: v = ZW'(469367);
      12: v = ZW'(234684);
      13: v = ZW'(117342);
      14: v = ZW'(58671);
      15: v = ZW'(29335);
      16: v = ZW'(14668);
      17: v = ZW'(7334);
      18: v = ZW'(3667);
      19: v = ZW'(1833);
      20: v = ZW'(917);
      21: v = ZW'(458);
      22: v = ZW'(229);
      23: v = ZW'(115);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

@@ hdl/accel_tilt_pitch_roll_unit.sv @@
`timescale 1ns / 1ps
// Channel   Ports                         Handshake
// input     start, busy, in_data          beat when start && !busy
// result    out_valid, out_data           one-cycle strobe, no backpressure
//
// Each beat passes through two square/sum stages, one stage per root bit
// of the square root, one stage per rotation and one rounding stage.
// A new beat can be taken every cycle while busy is low. busy is high only
// during reset and in the cycle after it. Reset clears the valid bits of
// every stage. The receiver cannot stall, so no stage ever holds a beat.
module accel_tilt_pitch_roll_unit #(
  parameter int CORDIC_STEPS = tpr_pkg::CORDIC_STEPS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  tpr_pkg::tpr_in_t   in_data,
  output logic               out_valid,
  output tpr_pkg::tpr_out_t  out_data
);

  localparam int ZW  = tpr_pkg::ZW;
  localparam int AW  = tpr_pkg::ANGLE_W;
  localparam int SH  = tpr_pkg::TABLE_FRAC - tpr_pkg::ANGLE_FRAC_BITS;
  localparam int LAT = 2 + tpr_pkg::ROOT_W + CORDIC_STEPS + 1;

  logic                          busy_r;
  logic                          accept;
  logic                          sq_valid, rt_valid, rt_valid_roll, cd_valid, cd_valid_roll;
  logic [tpr_pkg::SUM_W-1:0]     p_sum, r_sum;
  logic [tpr_pkg::MAG_W-1:0]     p_mag, r_mag, p_mag_rt, r_mag_rt;
  logic [tpr_pkg::ROOT_W-1:0]    p_root, r_root;
  tpr_pkg::tpr_side_t            p_side, r_side, p_side_rt, r_side_rt, p_side_cd, r_side_cd;
  logic signed [ZW-1:0]          p_z, r_z;
  logic                          out_valid_r;
  tpr_pkg::tpr_out_t             out_nxt, out_r;

  // round, clamp and sign one accumulated angle
  function automatic logic signed [AW-1:0] finish(input tpr_pkg::tpr_side_t sd,
                                                  input logic signed [ZW-1:0] z);
    logic signed [ZW-1:0] full;
    logic signed [ZW-1:0] zc;
    logic signed [ZW-1:0] r;
    full = ZW'(tpr_pkg::FULL_ANGLE);
    zc   = z[ZW-1] ? '0 : z;
    r    = (zc + (ZW'(1) <<< (SH - 1))) >>> SH;
    if (r > full) r = full;
    if (sd.num_zero) begin
      return '0;
    end
    if (sd.den_zero) begin
      return sd.neg ? AW'(-full) : AW'(full);
    end
    return sd.neg ? AW'(-r) : AW'(r);
  endfunction

  // hold off beats until reset has settled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy   = busy_r;
  assign accept = start && !busy_r;

  tpr_sqsum u_sqsum (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (accept),
    .in_data    (in_data),
    .out_valid  (sq_valid),
    .pitch_sum  (p_sum),
    .roll_sum   (r_sum),
    .pitch_mag  (p_mag),
    .roll_mag   (r_mag),
    .pitch_side (p_side),
    .roll_side  (r_side)
  );

  tpr_isqrt u_isqrt_pitch (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sq_valid),
    .in_sum    (p_sum),
    .in_mag    (p_mag),
    .in_side   (p_side),
    .out_valid (rt_valid),
    .out_root  (p_root),
    .out_mag   (p_mag_rt),
    .out_side  (p_side_rt)
  );

  tpr_isqrt u_isqrt_roll (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sq_valid),
    .in_sum    (r_sum),
    .in_mag    (r_mag),
    .in_side   (r_side),
    .out_valid (rt_valid_roll),
    .out_root  (r_root),
    .out_mag   (r_mag_rt),
    .out_side  (r_side_rt)
  );

  tpr_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_pitch (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (rt_valid),
    .in_root   (p_root),
    .in_mag    (p_mag_rt),
    .in_side   (p_side_rt),
    .out_valid (cd_valid),
    .out_angle (p_z),
    .out_side  (p_side_cd)
  );

  tpr_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_roll (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (rt_valid_roll),
    .in_root   (r_root),
    .in_mag    (r_mag_rt),
    .in_side   (r_side_rt),
    .out_valid (cd_valid_roll),
    .out_angle (r_z),
    .out_side  (r_side_cd)
  );

  // assemble the result beat
  always_comb begin
    out_nxt.pitch_angle     = finish(p_side_cd, p_z);
    out_nxt.roll_angle      = finish(r_side_cd, r_z);
    out_nxt.pitch_undefined = p_side_cd.num_zero && p_side_cd.den_zero;
    out_nxt.roll_undefined  = r_side_cd.num_zero && r_side_cd.den_zero;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cd_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // both angle lanes stay in lockstep
  a_lanes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    (cd_valid == cd_valid_roll) && (rt_valid == rt_valid_roll))
    else $error("pitch and roll lanes out of step");

  // every taken beat comes out a fixed latency later
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid == ($past(accept, LAT) === 1'b1))
    else $error("result strobe does not match accepted beat");

  // undefined result carries a zero angle
  a_undef_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.pitch_undefined || out_data.roll_undefined) |->
      (!out_data.pitch_undefined || out_data.pitch_angle == '0) &&
      (!out_data.roll_undefined || out_data.roll_angle == '0))
    else $error("undefined flag with nonzero angle");

  // angles stay within plus or minus ninety degrees
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      (out_data.pitch_angle <= AW'(tpr_pkg::FULL_ANGLE)) &&
      (out_data.pitch_angle >= AW'(-tpr_pkg::FULL_ANGLE)) &&
      (out_data.roll_angle <= AW'(tpr_pkg::FULL_ANGLE)) &&
      (out_data.roll_angle >= AW'(-tpr_pkg::FULL_ANGLE)))
    else $error("angle out of range");

endmodule

@@ hdl/tpr_sqsum.sv @@
`timescale 1ns / 1ps
module tpr_sqsum (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  tpr_pkg::tpr_in_t              in_data,
  output logic                          out_valid,
  output logic [tpr_pkg::SUM_W-1:0]     pitch_sum,
  output logic [tpr_pkg::SUM_W-1:0]     roll_sum,
  output logic [tpr_pkg::MAG_W-1:0]     pitch_mag,
  output logic [tpr_pkg::MAG_W-1:0]     roll_mag,
  output tpr_pkg::tpr_side_t            pitch_side,
  output tpr_pkg::tpr_side_t            roll_side
);

  localparam int SW = tpr_pkg::SAMPLE_WIDTH;
  localparam int MW = tpr_pkg::MAG_W;
  localparam int QW = tpr_pkg::SUM_W;

  logic signed [MW-1:0] xe, ye;
  logic signed [QW-1:0] px, py, pz;
  logic [MW-1:0]        xm, ym;
  tpr_pkg::tpr_side_t   ps_nxt, rs_nxt;

  logic                 v1_r, v2_r;
  logic [QW-2:0]        sqx_r, sqy_r, sqz_r;
  logic [MW-1:0]        pm1_r, rm1_r, pm2_r, rm2_r;
  tpr_pkg::tpr_side_t   ps1_r, rs1_r, ps2_r, rs2_r;
  logic [QW-1:0]        psum_r, rsum_r;

  // square the axes and find magnitudes and special cases
  always_comb begin
    xe = MW'(in_data.accel_x);
    ye = MW'(in_data.accel_y);
    xm = xe[MW-1] ? MW'(-xe) : MW'(xe);
    ym = ye[MW-1] ? MW'(-ye) : MW'(ye);
    px = in_data.accel_x * in_data.accel_x;
    py = in_data.accel_y * in_data.accel_y;
    pz = in_data.accel_z * in_data.accel_z;
    ps_nxt.neg      = !in_data.accel_x[SW-1] && (in_data.accel_x != '0);
    ps_nxt.num_zero = (in_data.accel_x == '0);
    ps_nxt.den_zero = (in_data.accel_y == '0) && (in_data.accel_z == '0);
    rs_nxt.neg      = in_data.accel_y[SW-1];
    rs_nxt.num_zero = (in_data.accel_y == '0);
    rs_nxt.den_zero = (in_data.accel_x == '0) && (in_data.accel_z == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  // register squares, then add pairs
  always_ff @(posedge clk) begin
    sqx_r  <= px[QW-2:0];
    sqy_r  <= py[QW-2:0];
    sqz_r  <= pz[QW-2:0];
    pm1_r  <= xm;
    rm1_r  <= ym;
    ps1_r  <= ps_nxt;
    rs1_r  <= rs_nxt;
    psum_r <= QW'(sqy_r) + QW'(sqz_r);
    rsum_r <= QW'(sqx_r) + QW'(sqz_r);
    pm2_r  <= pm1_r;
    rm2_r  <= rm1_r;
    ps2_r  <= ps1_r;
    rs2_r  <= rs1_r;
  end

  assign out_valid  = v2_r;
  assign pitch_sum  = psum_r;
  assign roll_sum   = rsum_r;
  assign pitch_mag  = pm2_r;
  assign roll_mag   = rm2_r;
  assign pitch_side = ps2_r;
  assign roll_side  = rs2_r;

endmodule

@@ hdl/tpr_isqrt.sv @@
`timescale 1ns / 1ps
module tpr_isqrt (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic [tpr_pkg::SUM_W-1:0]     in_sum,
  input  logic [tpr_pkg::MAG_W-1:0]     in_mag,
  input  tpr_pkg::tpr_side_t            in_side,
  output logic                          out_valid,
  output logic [tpr_pkg::ROOT_W-1:0]    out_root,
  output logic [tpr_pkg::MAG_W-1:0]     out_mag,
  output tpr_pkg::tpr_side_t            out_side
);

  localparam int RW = tpr_pkg::ROOT_W;
  localparam int MW = tpr_pkg::REM_W;

  logic [MW-1:0]               rem_s  [RW+1];
  logic [RW-1:0]               root_s [RW+1];
  logic [tpr_pkg::MAG_W-1:0]   mag_s  [RW+1];
  tpr_pkg::tpr_side_t          side_s [RW+1];
  logic                        vld_s  [RW+1];

  // radicand is the sum scaled by the guard bits
  assign rem_s[0]  = MW'(in_sum) << (2 * tpr_pkg::GUARD_BITS);
  assign root_s[0] = '0;
  assign mag_s[0]  = in_mag;
  assign side_s[0] = in_side;
  assign vld_s[0]  = in_valid;

  // one root bit per stage, most significant first
  for (genvar s = 0; s < RW; s++) begin : g_stage
    localparam int K = RW - 1 - s;
    logic [MW-1:0] trial;
    logic          take;

    assign trial = (MW'(root_s[s]) << (K + 1)) | (MW'(1) << (2 * K));
    assign take  = (rem_s[s] >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_s[s+1] <= 1'b0;
      end else begin
        vld_s[s+1] <= vld_s[s];
      end
    end

    always_ff @(posedge clk) begin
      rem_s[s+1]  <= take ? rem_s[s] - trial : rem_s[s];
      root_s[s+1] <= take ? (root_s[s] | (RW'(1) << K)) : root_s[s];
      mag_s[s+1]  <= mag_s[s];
      side_s[s+1] <= side_s[s];
    end
  end

  assign out_valid = vld_s[RW];
  assign out_root  = root_s[RW];
  assign out_mag   = mag_s[RW];
  assign out_side  = side_s[RW];

endmodule

@@ hdl/tpr_cordic.sv @@
`timescale 1ns / 1ps
module tpr_cordic #(
  parameter int STEPS = tpr_pkg::CORDIC_STEPS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic [tpr_pkg::ROOT_W-1:0]        in_root,
  input  logic [tpr_pkg::MAG_W-1:0]         in_mag,
  input  tpr_pkg::tpr_side_t                in_side,
  output logic                              out_valid,
  output logic signed [tpr_pkg::ZW-1:0]     out_angle,
  output tpr_pkg::tpr_side_t                out_side
);

  localparam int CW = tpr_pkg::CW;
  localparam int ZW = tpr_pkg::ZW;

  logic signed [CW-1:0]  x_s    [STEPS+1];
  logic signed [CW-1:0]  y_s    [STEPS+1];
  logic signed [ZW-1:0]  z_s    [STEPS+1];
  tpr_pkg::tpr_side_t    side_s [STEPS+1];
  logic                  vld_s  [STEPS+1];

  // start vector: denominator on x, scaled numerator magnitude on y
  assign x_s[0]    = CW'(in_root);
  assign y_s[0]    = CW'(in_mag) << tpr_pkg::GUARD_BITS;
  assign z_s[0]    = '0;
  assign side_s[0] = in_side;
  assign vld_s[0]  = in_valid;

  // one vectoring rotation per stage
  for (genvar i = 0; i < STEPS; i++) begin : g_step
    logic signed [CW-1:0] xs, ys;

    assign xs = x_s[i] >>> i;
    assign ys = y_s[i] >>> i;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_s[i+1] <= 1'b0;
      end else begin
        vld_s[i+1] <= vld_s[i];
      end
    end

    always_ff @(posedge clk) begin
      if (!y_s[i][CW-1]) begin
        x_s[i+1] <= x_s[i] + ys;
        y_s[i+1] <= y_s[i] - xs;
        z_s[i+1] <= z_s[i] + tpr_pkg::atan_deg(i);
      end else begin
        x_s[i+1] <= x_s[i] - ys;
        y_s[i+1] <= y_s[i] + xs;
        z_s[i+1] <= z_s[i] - tpr_pkg::atan_deg(i);
      end
      side_s[i+1] <= side_s[i];
    end
  end

  assign out_valid = vld_s[STEPS];
  assign out_angle = z_s[STEPS];
  assign out_side  = side_s[STEPS];

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;
  import tpr_pkg::*;

  localparam int LATENCY = 2 + ROOT_W + CORDIC_STEPS + 1;

  logic     clk;
  logic     rst_n;
  logic     start;
  logic     busy;
  tpr_in_t  in_data;
  logic     out_valid;
  tpr_out_t out_data;
  int       fail_count;

  accel_tilt_pitch_roll_unit dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_data(in_data), .out_valid(out_valid), .out_data(out_data)
  );

  // atan(2^-i) in degrees scaled by 2^24
  localparam longint ATAN_TAB [24] = '{
    754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
    15018523, 7509720, 3754917, 1877466, 938734, 469367,
    234684, 117342, 58671, 29335, 14668, 7334,
    3667, 1833, 917, 458, 229, 115
  };

  // floor square root, bit by bit
  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // one tilt angle by CORDIC vectoring, returned in degrees * 2^8
  function automatic void tilt_deg(input longint num, input longint a, input longint b,
                                   output logic signed [ANGLE_W-1:0] ang,
                                   output logic undef);
    longint unsigned sum;
    longint full, xv, yv, zacc, r, xs, ys;
    sum = longint'(a * a) + longint'(b * b);
    full = longint'(FULL_ANGLE);
    undef = 1'b0;
    zacc = 0;
    if (num == 0) begin
      undef = (sum == 0);
      ang = '0;
      return;
    end
    if (sum == 0) begin
      ang = ANGLE_W'(num > 0 ? full : -full);
      return;
    end
    xv = longint'(floor_sqrt(sum << (2 * GUARD_BITS)));
    yv = (num < 0 ? -num : num) << GUARD_BITS;
    for (int i = 0; i < CORDIC_STEPS && i < TABLE_LEN; i++) begin
      xs = xv >>> i;
      ys = yv >>> i;
      if (yv >= 0) begin
        xv = xv + ys;
        yv = yv - xs;
        zacc = zacc + ATAN_TAB[i];
      end else begin
        xv = xv - ys;
        yv = yv + xs;
        zacc = zacc - ATAN_TAB[i];
      end
    end
    if (zacc < 0) zacc = 0;
    r = (zacc + (longint'(1) << (TABLE_FRAC - ANGLE_FRAC_BITS - 1)))
        >>> (TABLE_FRAC - ANGLE_FRAC_BITS);
    if (r > full) r = full;
    ang = ANGLE_W'(num < 0 ? -r : r);
  endfunction

  function automatic tpr_out_t predict_tilt(tpr_in_t s);
    tpr_out_t o;
    longint x, y, z;
    x = longint'(s.accel_x);
    y = longint'(s.accel_y);
    z = longint'(s.accel_z);
    tilt_deg(-x, y, z, o.pitch_angle, o.pitch_undefined);
    tilt_deg(y, x, z, o.roll_angle, o.roll_undefined);
    return o;
  endfunction

  // pending angle results in order of acceptance
  class tilt_scoreboard;
    tpr_out_t pending_angles[$];

    function void note_sample(tpr_in_t s);
      pending_angles.push_back(predict_tilt(s));
    endfunction

    function void check_angles(tpr_out_t got);
      tpr_out_t exp_o;
      if (pending_angles.size() == 0) begin
        $error("unexpected result beat %h", got);
        fail_count++;
        return;
      end
      exp_o = pending_angles.pop_front();
      if (got.pitch_angle !== exp_o.pitch_angle) begin
        $error("pitch_angle exp %0d got %0d", exp_o.pitch_angle, got.pitch_angle);
        fail_count++;
      end
      if (got.roll_angle !== exp_o.roll_angle) begin
        $error("roll_angle exp %0d got %0d", exp_o.roll_angle, got.roll_angle);
        fail_count++;
      end
      if (got.pitch_undefined !== exp_o.pitch_undefined) begin
        $error("pitch_undefined exp %0b got %0b", exp_o.pitch_undefined,
               got.pitch_undefined);
        fail_count++;
      end
      if (got.roll_undefined !== exp_o.roll_undefined) begin
        $error("roll_undefined exp %0b got %0b", exp_o.roll_undefined,
               got.roll_undefined);
        fail_count++;
      end
    endfunction
  endclass

  tilt_scoreboard sb;

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // check every result strobe
  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_angles(out_data);
  end

  // drive one sample; hold until accepted
  task automatic send_sample(logic [15:0] x, logic [15:0] y, logic [15:0] z);
    start <= 1'b1;
    in_data <= '{accel_x: x, accel_y: y, accel_z: z};
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_sample(in_data);
  endtask

  task automatic idle_cycles(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // random axis value, leaning toward zero and extremes
  function automatic logic [15:0] rand_axis();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'h8000;
      2: return 16'h7fff;
      3: return 16'(int'($urandom_range(0, 15)) - 8);
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    logic [15:0] edge_vals [6];
    int burst;
    edge_vals = '{16'h0000, 16'h0001, 16'hffff, 16'h7fff, 16'h8000, 16'h4000};
    sb = new();
    fail_count = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed: all zero, single axes, extremes
    send_sample(16'h0000, 16'h0000, 16'h0000);
    for (int i = 1; i < 6; i++) begin
      send_sample(edge_vals[i], 16'h0000, 16'h0000);
      send_sample(16'h0000, edge_vals[i], 16'h0000);
      send_sample(16'h0000, 16'h0000, edge_vals[i]);
    end
    send_sample(16'h8000, 16'h8000, 16'h8000);
    send_sample(16'h7fff, 16'h7fff, 16'h7fff);
    send_sample(16'h8000, 16'h7fff, 16'h0001);
    send_sample(16'h0100, 16'hff00, 16'h4000);

    // hold off until the pipeline drains
    idle_cycles(1);
    while (sb.pending_angles.size() != 0) @(posedge clk);

    // random bursts with random gaps
    for (int n = 0; n < 400; n += burst) begin
      burst = $urandom_range(1, 30);
      for (int k = 0; k < burst; k++) send_sample(rand_axis(), rand_axis(), rand_axis());
      if ($urandom_range(0, 2) != 0) idle_cycles($urandom_range(1, 60));
    end
    start <= 1'b0;

    while (sb.pending_angles.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
    if (fail_count == 0 && sb.pending_angles.size() == 0) begin
      $display("** accel_tilt_pitch_roll_unit: PASSED **");
    end else begin
      $display("** accel_tilt_pitch_roll_unit: FAILED **");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("** accel_tilt_pitch_roll_unit: FAILED **");
    $finish;
  end
endmodule
